[sv/actuator_joint_angle_converter_macros.svh]
// Assertion helpers for the converter RTL
`ifndef ACTUATOR_JOINT_ANGLE_CONVERTER_MACROS_SVH
`define ACTUATOR_JOINT_ANGLE_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clock, muted in reset
`define AJAC_ASSERT_IMPLIES(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("ajac assertion failed");

// Next-cycle implication
`define AJAC_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("ajac assertion failed");

`endif

[sv/ajac_pkg.sv]
`default_nettype none
package ajac_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int ZW           = 34;   // Q30 angle accumulator
   localparam int CORDIC_ROT_W = 34;   // rotation datapath, |x|,|y| just over 2^30
   localparam int RED_W        = 36;   // range-reduced angle magnitude, Q30

   localparam longint Q30_ONE      = 64'sd1073741824;
   localparam longint Q30_PI       = 64'sd3373259426;
   localparam longint Q30_TWO_PI   = 64'sd6746518852;
   localparam longint Q30_HALF_PI  = 64'sd1686629713;
   localparam longint CORDIC_GAIN_INV = 64'sd652032874;

   localparam logic [1:0] REG_LEFT_LEN  = 2'd0;
   localparam logic [1:0] REG_RIGHT_LEN = 2'd1;
   localparam logic [1:0] REG_LEFT_ANG  = 2'd2;
   localparam logic [1:0] REG_RIGHT_ANG = 2'd3;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0: v = ZW'(64'sd843314857);
         1: v = ZW'(64'sd497837829);
         2: v = ZW'(64'sd263043837);
         3: v = ZW'(64'sd133525159);
         4: v = ZW'(64'sd67021688);
         5: v = ZW'(64'sd33543516);
         6: v = ZW'(64'sd16775851);
         7: v = ZW'(64'sd8388437);
         8: v = ZW'(64'sd4194283);
         9: v = ZW'(64'sd2097149);
         default: v = {{(ZW-1){1'b0}}, 1'b1} << (30 - idx);
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[sv/actuator_joint_angle_converter.sv]
// Channel   Ports                                    Handshake
// request   req_action, req_extension_in, req_angle_in  start high, busy low
// result    rsp_angle_out, rsp_extension_out, rsp_range_fault  rsp_valid strobe, 1 cycle
// config    psel penable pwrite paddr pwdata prdata     APB, pready tied high
//
// One transaction per cycle, back to back; busy never rises.
// The result passes through the square-root pipelines (one root bit per stage)
// and the 30-stage CORDIC pipelines.
// Synchronous reset clears the config registers and every pipeline valid bit.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none
`include "actuator_joint_angle_converter_macros.svh"
module actuator_joint_angle_converter #(
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int LENGTH_WIDTH    = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [LENGTH_WIDTH-1:0]           req_extension_in,
   input  logic signed [ANGLE_FRAC_BITS+3:0] req_angle_in,
   output logic                              rsp_valid,
   output logic signed [ANGLE_FRAC_BITS+3:0] rsp_angle_out,
   output logic [LENGTH_WIDTH-1:0]           rsp_extension_out,
   output logic                              rsp_range_fault,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [3:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ajac_pkg::*;

   localparam int LW    = LENGTH_WIDTH;
   localparam int AF    = ANGLE_FRAC_BITS;
   localparam int AIN_W = AF + 4;
   localparam int AMT_W = AF + 3;
   localparam int SPW   = AF + 6;
   localparam int NA    = LW + 27;
   localparam int NB    = LW + 22;
   localparam int CVW   = LW + 30;
   localparam int CRW   = CORDIC_ROT_W;
   localparam int XW    = 2 * LW + 32;
   localparam int AZW   = ZW + 2;

   localparam logic signed [SPW-1:0] ANG_MAX = SPW'((64'sd1 <<< (AIN_W - 1)) - 64'sd1);
   localparam logic signed [SPW-1:0] ANG_MIN = SPW'(-(64'sd1 <<< (AIN_W - 1)));
   localparam logic signed [CRW:0]   COS_MAX = (CRW + 1)'(Q30_ONE);
   localparam logic signed [CRW:0]   COS_MIN = (CRW + 1)'(-Q30_ONE);
   localparam logic [RED_W-1:0]      RED_TWO_PI  = RED_W'(Q30_TWO_PI);
   localparam logic [RED_W-1:0]      RED_PI      = RED_W'(Q30_PI);
   localparam logic [RED_W-1:0]      RED_HALF_PI = RED_W'(Q30_HALF_PI);

   // configuration
   logic [LW-1:0]           left_len_ff, right_len_ff;
   logic signed [AMT_W-1:0] left_ang_ff, right_ang_ff;
   logic [2*LW-1:0]         ll_ff, rr_ff, lr_ff;

   assign pready = 1'b1;
   assign busy   = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_len_ff  <= '0;
         right_len_ff <= '0;
         left_ang_ff  <= '0;
         right_ang_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_LEFT_LEN:  left_len_ff  <= pwdata[LW-1:0];
            REG_RIGHT_LEN: right_len_ff <= pwdata[LW-1:0];
            REG_LEFT_ANG:  left_ang_ff  <= pwdata[AMT_W-1:0];
            REG_RIGHT_ANG: right_ang_ff <= pwdata[AMT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LEFT_LEN:  prdata = 32'(left_len_ff);
         REG_RIGHT_LEN: prdata = 32'(right_len_ff);
         REG_LEFT_ANG:  prdata = 32'(unsigned'(left_ang_ff));
         REG_RIGHT_ANG: prdata = 32'(unsigned'(right_ang_ff));
         default:       prdata = '0;
      endcase
   end

   // side products: user must change config only between idle periods, long before they are used; unenforced
   always_ff @(posedge clock) begin
      ll_ff <= (2 * LW)'(left_len_ff) * (2 * LW)'(left_len_ff);
      rr_ff <= (2 * LW)'(right_len_ff) * (2 * LW)'(right_len_ff);
      lr_ff <= (2 * LW)'(left_len_ff) * (2 * LW)'(right_len_ff);
   end

   logic req_accept;
   assign req_accept = start && !busy;

   // ---------------- angle from extension ----------------
   logic [LW-1:0] diff_len;
   logic [LW:0]   sum_len;
   logic          ext_below, ext_above;

   assign diff_len  = (left_len_ff > right_len_ff) ? left_len_ff - right_len_ff
                                                   : right_len_ff - left_len_ff;
   assign sum_len   = {1'b0, left_len_ff} + {1'b0, right_len_ff};
   assign ext_below = req_extension_in < diff_len;
   assign ext_above = {1'b0, req_extension_in} > sum_len;

   logic          a1_valid_ff, a1_action_ff, a1_below_ff, a1_above_ff;
   logic [LW:0]   a1_sme_ff, a1_epd_ff;
   logic [LW+1:0] a1_spe_ff;
   logic [LW-1:0] a1_emd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
      end else begin
         a1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      a1_action_ff <= req_action;
      a1_below_ff  <= ext_below;
      a1_above_ff  <= ext_above;
      a1_sme_ff    <= sum_len - {1'b0, req_extension_in};
      a1_spe_ff    <= {1'b0, sum_len} + {2'b00, req_extension_in};
      a1_emd_ff    <= req_extension_in - diff_len;
      a1_epd_ff    <= {1'b0, req_extension_in} + {1'b0, diff_len};
   end

   logic [2*LW+2:0] px_full;
   logic [2*LW:0]   py_full;
   logic            a2_valid_ff, a2_action_ff, a2_below_ff, a2_above_ff;
   logic [2*LW+1:0] a2_px_ff;
   logic [2*LW-1:0] a2_py_ff;

   assign px_full = (2 * LW + 3)'(a1_sme_ff) * (2 * LW + 3)'(a1_spe_ff);
   assign py_full = (2 * LW + 1)'(a1_emd_ff) * (2 * LW + 1)'(a1_epd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_valid_ff <= 1'b0;
      end else begin
         a2_valid_ff <= a1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a2_action_ff <= a1_action_ff;
      a2_below_ff  <= a1_below_ff;
      a2_above_ff  <= a1_above_ff;
      a2_px_ff     <= px_full[2*LW+1:0];
      a2_py_ff     <= py_full[2*LW-1:0];
   end

   logic          sqx_valid, sqy_valid, sqy_action;
   logic [NA-1:0] sqx_root, sqy_root;
   logic [1:0]    sqx_side;

   ajac_sqrt #(.ROOT_W(NA), .SIDE_W(2)) u_sqrt_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a2_valid_ff),
      .in_value  ({a2_px_ff, 52'd0}),
      .in_side   ({a2_below_ff, a2_above_ff}),
      .out_valid (sqx_valid),
      .out_root  (sqx_root),
      .out_side  (sqx_side)
   );

   ajac_sqrt #(.ROOT_W(NA), .SIDE_W(1)) u_sqrt_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a2_valid_ff),
      .in_value  ({2'b00, a2_py_ff, 52'd0}),
      .in_side   (a2_action_ff),
      .out_valid (sqy_valid),
      .out_root  (sqy_root),
      .out_side  (sqy_action)
   );

   logic                 va_valid;
   logic signed [ZW-1:0] va_z;
   logic [2:0]           va_side;   // action, below, above

   ajac_cordic #(.W(CVW), .VECTORING(1'b1), .SIDE_W(3)) u_cordic_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqx_valid),
      .in_x      (signed'({3'b000, sqx_root})),
      .in_y      (signed'({3'b000, sqy_root})),
      .in_z      ('0),
      .in_side   ({sqy_action, sqx_side}),
      .out_valid (va_valid),
      .out_x     (),
      .out_z     (va_z),
      .out_side  (va_side)
   );

   // ---------------- extension from goal angle ----------------
   logic signed [SPW-1:0] span;
   logic [SPW-1:0]        span_mag;

   assign span     = SPW'(req_angle_in) - SPW'(left_ang_ff) - SPW'(right_ang_ff);
   assign span_mag = span[SPW-1] ? unsigned'(-span) : unsigned'(span);

   logic             b1_valid_ff, b1_action_ff;
   logic [RED_W-1:0] b1_a_ff, b2_a_ff, b3_a_ff;
   logic             b2_valid_ff, b2_action_ff, b3_valid_ff, b3_action_ff;
   logic             b4_valid_ff, b4_action_ff, b4_neg_ff;
   logic signed [ZW-1:0] b4_z_ff;
   logic [RED_W-1:0] red3, fold3;

   assign red3  = (b2_a_ff >= RED_TWO_PI) ? b2_a_ff - RED_TWO_PI : b2_a_ff;
   assign fold3 = (red3 > RED_PI) ? RED_TWO_PI - red3 : red3;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= req_accept;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_action_ff <= req_action;
      b1_a_ff      <= RED_W'(span_mag) << (30 - AF);
      b2_action_ff <= b1_action_ff;
      b2_a_ff      <= (b1_a_ff >= RED_TWO_PI) ? b1_a_ff - RED_TWO_PI : b1_a_ff;
      b3_action_ff <= b2_action_ff;
      b3_a_ff      <= fold3;
      b4_action_ff <= b3_action_ff;
      b4_neg_ff    <= b3_a_ff > RED_HALF_PI;
      b4_z_ff      <= (b3_a_ff > RED_HALF_PI) ? signed'(ZW'(RED_PI - b3_a_ff))
                                              : signed'(ZW'(b3_a_ff));
   end

   logic                  vb_valid;
   logic signed [CRW-1:0] vb_x;
   logic [1:0]            vb_side;   // action, fold negates

   ajac_cordic #(.W(CRW), .VECTORING(1'b0), .SIDE_W(2)) u_cordic_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b4_valid_ff),
      .in_x      (CRW'(CORDIC_GAIN_INV)),
      .in_y      ('0),
      .in_z      (b4_z_ff),
      .in_side   ({b4_action_ff, b4_neg_ff}),
      .out_valid (vb_valid),
      .out_x     (vb_x),
      .out_z     (),
      .out_side  (vb_side)
   );

   logic signed [CRW:0] cos_ext, cos_sgn, cos_clamped, cos_abs;

   assign cos_ext = (CRW + 1)'(vb_x);
   assign cos_sgn = vb_side[0] ? -cos_ext : cos_ext;

   always_comb begin
      if (cos_sgn > COS_MAX) begin
         cos_clamped = COS_MAX;
      end else if (cos_sgn < COS_MIN) begin
         cos_clamped = COS_MIN;
      end else begin
         cos_clamped = cos_sgn;
      end
   end

   assign cos_abs = cos_clamped[CRW] ? -cos_clamped : cos_clamped;

   logic        b5_valid_ff, b5_action_ff, b5_cneg_ff;
   logic [30:0] b5_cabs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b5_valid_ff <= 1'b0;
      end else begin
         b5_valid_ff <= vb_valid;
      end
   end

   always_ff @(posedge clock) begin
      b5_action_ff <= vb_side[1];
      b5_cneg_ff   <= cos_clamped[CRW];
      b5_cabs_ff   <= cos_abs[30:0];
   end

   // 2LR|c| split into two 32-bit partial products
   logic [63:0]   lr_wide;
   logic          b6_valid_ff, b6_action_ff, b6_cneg_ff;
   logic [62:0]   b6_plo_ff, b6_phi_ff;
   logic [2*LW:0] b6_sq_ff;

   assign lr_wide = 64'(lr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b6_valid_ff <= 1'b0;
      end else begin
         b6_valid_ff <= b5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b6_action_ff <= b5_action_ff;
      b6_cneg_ff   <= b5_cneg_ff;
      b6_plo_ff    <= 63'(lr_wide[31:0]) * 63'(b5_cabs_ff);
      b6_phi_ff    <= 63'(lr_wide[63:32]) * 63'(b5_cabs_ff);
      b6_sq_ff     <= {1'b0, ll_ff} + {1'b0, rr_ff};
   end

   logic [94:0]   prod_full;
   logic [XW-1:0] prod2, base_sq;
   logic          b7_valid_ff, b7_action_ff;
   logic [XW-1:0] b7_x_ff;

   assign prod_full = {b6_phi_ff, 32'd0} + 95'(b6_plo_ff);
   assign prod2     = XW'(prod_full) << 1;
   assign base_sq   = XW'(b6_sq_ff) << 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         b7_valid_ff <= 1'b0;
      end else begin
         b7_valid_ff <= b6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b7_action_ff <= b6_action_ff;
      b7_x_ff      <= b6_cneg_ff ? base_sq + prod2 : base_sq - prod2;
   end

   logic          vbs_valid, vbs_action;
   logic [NB-1:0] vbs_root;

   ajac_sqrt #(.ROOT_W(NB), .SIDE_W(1)) u_sqrt_ext (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b7_valid_ff),
      .in_value  ((2 * NB)'(b7_x_ff)),
      .in_side   (b7_action_ff),
      .out_valid (vbs_valid),
      .out_root  (vbs_root),
      .out_side  (vbs_action)
   );

   // ---------------- result ----------------
   logic                  len_zero;
   logic signed [AZW-1:0] a30, a_round;
   logic signed [SPW-1:0] ang_sum, ang_sat;
   logic                  ang_hi, ang_lo, ext_over;
   logic [LW-1:0]         ext_val;
   logic                  fault;

   assign len_zero = (left_len_ff == '0) || (right_len_ff == '0);

   always_comb begin
      if (len_zero || va_side[1]) begin
         a30 = '0;
      end else if (va_side[0]) begin
         a30 = AZW'(Q30_PI);
      end else begin
         a30 = AZW'(va_z) <<< 1;
      end
   end

   assign a_round = (a30 + AZW'(64'sd1 <<< (29 - AF))) >>> (30 - AF);
   assign ang_sum = SPW'(a_round) + SPW'(left_ang_ff) + SPW'(right_ang_ff);
   assign ang_hi  = ang_sum > ANG_MAX;
   assign ang_lo  = ang_sum < ANG_MIN;
   assign ang_sat = ang_hi ? ANG_MAX : (ang_lo ? ANG_MIN : ang_sum);

   assign ext_over = |vbs_root[NB-1:LW+15];
   assign ext_val  = ext_over ? '1 : vbs_root[LW+14:15];

   assign fault = len_zero ||
                  (va_side[2] ? ext_over : (va_side[1] || va_side[0] || ang_hi || ang_lo));

   logic                    rsp_valid_ff, rsp_fault_ff;
   logic signed [AIN_W-1:0] rsp_angle_ff;
   logic [LW-1:0]           rsp_ext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= va_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff <= va_side[2] ? '0 : ang_sat[AIN_W-1:0];
      rsp_ext_ff   <= va_side[2] ? ext_val : '0;
      rsp_fault_ff <= fault;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_angle_out     = rsp_angle_ff;
   assign rsp_extension_out = rsp_ext_ff;
   assign rsp_range_fault   = rsp_fault_ff;

   `AJAC_ASSERT_IMPLIES(a_roots_aligned, sqx_valid, sqy_valid)
   `AJAC_ASSERT_IMPLIES(a_paths_aligned, va_valid, vbs_valid && (va_side[2] == vbs_action))
   `AJAC_ASSERT_IMPLIES(a_paths_aligned_rev, vbs_valid, va_valid)
   `AJAC_ASSERT_NEXT(a_result_follows, va_valid, rsp_valid)

endmodule
`default_nettype wire

[sv/ajac_sqrt.sv]
`default_nettype none
module ajac_sqrt #(
   parameter int ROOT_W = 8,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_value,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);
   // restoring square root, one root bit per stage
   logic                val_ff  [ROOT_W];
   logic [2*ROOT_W-1:0] rad_ff  [ROOT_W];
   logic [ROOT_W+1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [SIDE_W-1:0]   side_ff [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         logic                val_prev;
         logic [2*ROOT_W-1:0] rad_prev;
         logic [ROOT_W+1:0]   rem_prev;
         logic [ROOT_W-1:0]   root_prev;
         logic [SIDE_W-1:0]   side_prev;
         logic [ROOT_W+1:0]   rem_sh;
         logic [ROOT_W+1:0]   trial;
         logic [ROOT_W+1:0]   rem_in;
         logic [ROOT_W-1:0]   root_in;
         logic                ge;

         if (k == 0) begin : g_first
            assign val_prev  = in_valid;
            assign rad_prev  = in_value;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
         end else begin : g_next
            assign val_prev  = val_ff[k-1];
            assign rad_prev  = rad_ff[k-1];
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         assign rem_sh  = {rem_prev[ROOT_W-1:0], rad_prev[2*ROOT_W-1 -: 2]};
         assign trial   = {root_prev, 2'b01};
         assign ge      = rem_sh >= trial;
         assign rem_in  = ge ? rem_sh - trial : rem_sh;
         assign root_in = {root_prev[ROOT_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               val_ff[k] <= 1'b0;
            end else begin
               val_ff[k] <= val_prev;
            end
         end

         always_ff @(posedge clock) begin
            rad_ff[k]  <= rad_prev << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   endgenerate

   assign out_valid = val_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
endmodule
`default_nettype wire

[sv/ajac_cordic.sv]
`default_nettype none
module ajac_cordic #(
   parameter int W         = 34,
   parameter bit VECTORING = 1'b0,
   parameter int SIDE_W    = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [W-1:0]          in_x,
   input  logic signed [W-1:0]          in_y,
   input  logic signed [ajac_pkg::ZW-1:0] in_z,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic signed [W-1:0]          out_x,
   output logic signed [ajac_pkg::ZW-1:0] out_z,
   output logic [SIDE_W-1:0]            out_side
);
   import ajac_pkg::*;

   logic                 val_ff  [CORDIC_STEPS];
   logic signed [W-1:0]  x_ff    [CORDIC_STEPS];
   logic signed [W-1:0]  y_ff    [CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff    [CORDIC_STEPS];
   logic [SIDE_W-1:0]    side_ff [CORDIC_STEPS];

   genvar k;
   generate
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
         logic                 val_prev;
         logic signed [W-1:0]  x_prev;
         logic signed [W-1:0]  y_prev;
         logic signed [ZW-1:0] z_prev;
         logic [SIDE_W-1:0]    side_prev;
         logic signed [W-1:0]  dx;
         logic signed [W-1:0]  dy;
         logic signed [ZW-1:0] at;
         logic                 pos;

         if (k == 0) begin : g_first
            assign val_prev  = in_valid;
            assign x_prev    = in_x;
            assign y_prev    = in_y;
            assign z_prev    = in_z;
            assign side_prev = in_side;
         end else begin : g_next
            assign val_prev  = val_ff[k-1];
            assign x_prev    = x_ff[k-1];
            assign y_prev    = y_ff[k-1];
            assign z_prev    = z_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         assign dx  = y_prev >>> k;
         assign dy  = x_prev >>> k;
         assign at  = atan_q30(k);
         // vectoring drives y to zero, rotation drives z to zero
         assign pos = VECTORING ? y_prev[W-1] : !z_prev[ZW-1];

         always_ff @(posedge clock) begin
            if (reset) begin
               val_ff[k] <= 1'b0;
            end else begin
               val_ff[k] <= val_prev;
            end
         end

         always_ff @(posedge clock) begin
            x_ff[k]    <= pos ? x_prev - dx : x_prev + dx;
            y_ff[k]    <= pos ? y_prev + dy : y_prev - dy;
            z_ff[k]    <= pos ? z_prev - at : z_prev + at;
            side_ff[k] <= side_prev;
         end
      end
   endgenerate

   assign out_valid = val_ff[CORDIC_STEPS-1];
   assign out_x     = x_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_side  = side_ff[CORDIC_STEPS-1];
endmodule
`default_nettype wire
